### rtl/core/phist_pkg.sv
// ----------------------------------------------------------------------------
// Pixel histogram package
// Shared constants, item codes and the bin store write request type.
// ----------------------------------------------------------------------------
package phist_pkg;

  localparam int unsigned NUM_BINS   = 256;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned BIN_AW     = $clog2(NUM_BINS);
  localparam int unsigned LEVEL_BITS = 8;

  localparam logic [LEVEL_BITS-1:0] MAX_LEVEL_RESET = LEVEL_BITS'(255);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX       = '1;

  typedef enum logic [1:0] {
    MODE_COUNT = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef struct packed {
    logic                  en;
    logic [BIN_AW-1:0]     addr;
    logic [COUNT_BITS-1:0] data;
  } bin_wr_t;

endpackage

### rtl/core/pixel_histogram.sv
// ----------------------------------------------------------------------------
// Pixel histogram
// Counts pixels into intensity bins; bins can also be read and overwritten.
// ----------------------------------------------------------------------------
// A result is strobed on done_o once its word has passed s1_valid_q and done_q.
// One word per cycle while busy is low; the bin RAM is read on acceptance
// and written back in the next cycle, forwarding between neighboring words.
// busy is high only while a configuration write is presented.
// Reset clears all bins through per-bin valid bits and sets max_level to 255.
// The receiver cannot stall, so no result is ever held back.
module pixel_histogram (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  pixel_value_i,
  input  logic [7:0]  bin_index_i,
  input  logic [31:0] bin_value_i,
  output logic        done_o,
  output logic [31:0] bin_count_o,
  output logic        out_of_range_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_max_level_i
);

  logic [phist_pkg::LEVEL_BITS-1:0] max_level_q;

  logic                             accept;
  phist_pkg::mode_e                 in_mode;
  logic [phist_pkg::BIN_AW-1:0]     in_addr;
  logic                             in_oor;

  logic                             s1_valid_q;
  phist_pkg::mode_e                 s1_mode_q;
  logic [phist_pkg::BIN_AW-1:0]     s1_addr_q;
  logic [phist_pkg::COUNT_BITS-1:0] s1_value_q;
  logic                             s1_oor_q;

  logic [phist_pkg::COUNT_BITS-1:0] cur_count;
  phist_pkg::bin_wr_t               bin_wr;

  logic                             done_q;
  logic [phist_pkg::COUNT_BITS-1:0] count_q;
  logic                             oor_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = cfg_valid_i;
  assign accept      = start && !busy;
  assign in_mode     = phist_pkg::mode_e'(mode_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= phist_pkg::MAX_LEVEL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_level_q <= cfg_max_level_i;
    end
  end

  always_comb begin
    in_addr = bin_index_i;
    in_oor  = 1'b0;
    case (in_mode)
      phist_pkg::MODE_COUNT: begin
        in_addr = pixel_value_i;
        in_oor  = pixel_value_i > max_level_q;
      end
      phist_pkg::MODE_READ, phist_pkg::MODE_WRITE: begin
        in_oor = bin_index_i > max_level_q;
      end
      default: begin
        in_oor = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q  <= in_mode;
      s1_addr_q  <= in_addr;
      s1_value_q <= bin_value_i;
      s1_oor_q   <= in_oor;
    end
  end

  phist_bins u_bins (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_addr),
    .wr_i      (bin_wr),
    .rd_data_o (cur_count)
  );

  always_comb begin
    bin_wr.en   = 1'b0;
    bin_wr.addr = s1_addr_q;
    bin_wr.data = s1_value_q;
    if (s1_valid_q && !s1_oor_q) begin
      case (s1_mode_q)
        phist_pkg::MODE_COUNT: begin
          bin_wr.en   = cur_count != phist_pkg::COUNT_MAX;
          bin_wr.data = cur_count + phist_pkg::COUNT_BITS'(1);
        end
        phist_pkg::MODE_WRITE: begin
          bin_wr.en = 1'b1;
        end
        default: begin
          bin_wr.en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      count_q <= (s1_mode_q == phist_pkg::MODE_READ && !s1_oor_q) ? cur_count : '0;
      oor_q   <= s1_oor_q;
    end
  end

  assign done_o         = done_q;
  assign bin_count_o    = count_q;
  assign out_of_range_o = oor_q;

  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(s1_valid_q))
    else $error("result strobe without an item in flight");

  a_oor_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> (bin_count_o == '0))
    else $error("flagged item returned a nonzero count");

  a_no_oor_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_wr.en |-> (s1_valid_q && !s1_oor_q))
    else $error("bin written by an ignored item");

  a_accept_to_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted item did not reach the update stage");

endmodule

### rtl/core/phist_ram.sv
// ----------------------------------------------------------------------------
// Pixel histogram RAM
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module phist_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/phist_bins.sv
// ----------------------------------------------------------------------------
// Pixel histogram bin store
// Bin RAM with per-bin valid bits for reset clearing and write forwarding
// so that a read sees a write to the same bin issued in the same cycle.
// ----------------------------------------------------------------------------
module phist_bins (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [phist_pkg::BIN_AW-1:0]      rd_addr_i,
  input  phist_pkg::bin_wr_t                wr_i,
  output logic [phist_pkg::COUNT_BITS-1:0]  rd_data_o
);

  logic [phist_pkg::NUM_BINS-1:0]   valid_q;
  logic                             rd_valid_q;
  logic                             fwd_hit_q;
  logic [phist_pkg::COUNT_BITS-1:0] fwd_data_q;
  logic [phist_pkg::COUNT_BITS-1:0] ram_data;

  phist_ram #(
    .DEPTH (phist_pkg::NUM_BINS),
    .WIDTH (phist_pkg::COUNT_BITS),
    .AW    (phist_pkg::BIN_AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_i.en),
    .wr_addr_i (wr_i.addr),
    .wr_data_i (wr_i.data),
    .rd_en_i   (rd_en_i),
    .rd_addr_i (rd_addr_i),
    .rd_data_o (ram_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
        fwd_hit_q  <= wr_i.en && (wr_i.addr == rd_addr_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_i.data;
    end
  end

  assign rd_data_o = fwd_hit_q  ? fwd_data_q :
                     rd_valid_q ? ram_data   : '0;

endmodule

### test/phist_checker.sv
// ----------------------------------------------------------------------------
// Pixel histogram checker
// Watches the item, result and max_level channels of the pixel histogram,
// keeps its own copy of the bins to predict each result, and compares every
// strobed result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module phist_checker
  import phist_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  pixel_value_i,
  input  logic [7:0]  bin_index_i,
  input  logic [31:0] bin_value_i,
  input  logic        done_o,
  input  logic [31:0] bin_count_o,
  input  logic        out_of_range_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [7:0]  cfg_max_level_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic                  oor;
  } bin_result_t;

  logic [COUNT_BITS-1:0] hist_bins [NUM_BINS];
  logic [LEVEL_BITS-1:0] top_level;
  bin_result_t           expected_results [$];
  int                    fail_count = 0;
  int                    pending    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("mismatch at %0t: %s got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic predict_bin_result(input mode_e mode, input logic [7:0] pix,
                                    input logic [7:0] idx, input logic [31:0] val,
                                    output bin_result_t res);
    res = '0;
    case (mode)
      MODE_COUNT: begin
        if (pix > top_level) begin
          res.oor = 1'b1;
        end else if (hist_bins[pix] != COUNT_MAX) begin
          hist_bins[pix] = hist_bins[pix] + 1'b1;
        end
      end
      MODE_READ: begin
        if (idx > top_level) begin
          res.oor = 1'b1;
        end else begin
          res.count = hist_bins[idx];
        end
      end
      MODE_WRITE: begin
        if (idx > top_level) begin
          res.oor = 1'b1;
        end else begin
          hist_bins[idx] = val;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bin_result_t want;
    bin_result_t next_res;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_BINS; k++) begin
        hist_bins[k] = '0;
      end
      top_level = MAX_LEVEL_RESET;
      expected_results.delete();
    end else begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, bin_count", bin_count_o, '0);
        end else begin
          want = expected_results.pop_front();
          if (bin_count_o !== want.count) begin
            report_mismatch("bin_count", bin_count_o, want.count);
          end
          if (out_of_range_o !== want.oor) begin
            report_mismatch("out_of_range", 32'(out_of_range_o), 32'(want.oor));
          end
        end
      end
      if (start && !busy) begin
        predict_bin_result(mode_e'(mode_i), pixel_value_i, bin_index_i, bin_value_i,
                           next_res);
        expected_results.insert(expected_results.size(), next_res);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        top_level = cfg_max_level_i;
      end
    end
    pending = expected_results.size();
  end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Pixel histogram testbench
// Drives directed and random count, read, write and MODE_NONE words through several
// max_level settings with random gaps, while the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import phist_pkg::*;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start           = 1'b0;
  mode_e       mode_i          = MODE_COUNT;
  logic [7:0]  pixel_value_i   = '0;
  logic [7:0]  bin_index_i     = '0;
  logic [31:0] bin_value_i     = '0;
  logic        cfg_valid_i     = 1'b0;
  logic [7:0]  cfg_max_level_i = '0;
  logic        busy;
  logic        done_o;
  logic [31:0] bin_count_o;
  logic        out_of_range_o;
  logic        cfg_ready_o;
  int          fail_count;
  int          pending;
  logic [7:0]  cur_level = MAX_LEVEL_RESET;
  logic [7:0]  hot_bin   = '0;

  pixel_histogram u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .pixel_value_i  (pixel_value_i),
    .bin_index_i    (bin_index_i),
    .bin_value_i    (bin_value_i),
    .done_o         (done_o),
    .bin_count_o    (bin_count_o),
    .out_of_range_o (out_of_range_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_max_level_i(cfg_max_level_i)
  );

  phist_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .pixel_value_i  (pixel_value_i),
    .bin_index_i    (bin_index_i),
    .bin_value_i    (bin_value_i),
    .done_o         (done_o),
    .bin_count_o    (bin_count_o),
    .out_of_range_o (out_of_range_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_max_level_i(cfg_max_level_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  task automatic send_word(input mode_e mode, input logic [7:0] pix,
                           input logic [7:0] idx, input logic [31:0] val,
                           input int gap);
    start         <= 1'b1;
    mode_i        <= mode;
    pixel_value_i <= pix;
    bin_index_i   <= idx;
    bin_value_i   <= val;
    do @(posedge clk_i); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_max_level(input logic [7:0] level);
    wait_drained();
    repeat (2) @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_max_level_i <= level;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_level = level;
  endtask

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [7:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return hot_bin;
    if (r < 85) return 8'($urandom_range(0, cur_level));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    if (r == 2) return '0;
    return $urandom;
  endfunction

  initial begin
    logic [7:0] phase_levels [8];
    mode_e      mode;
    int         r;
    bit         quiet;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state, saturation, forwarding between neighboring words.
    send_word(MODE_READ,  8'd0,   8'd0,   32'h0, 0);
    send_word(MODE_READ,  8'd0,   8'd255, 32'h0, 0);
    send_word(MODE_COUNT, 8'd0,   8'd0,   32'h0, 0);
    send_word(MODE_COUNT, 8'd255, 8'd0,   32'h0, 0);
    send_word(MODE_COUNT, 8'd255, 8'd0,   32'h0, 0);
    send_word(MODE_READ,  8'd0,   8'd255, 32'h0, 0);
    send_word(MODE_READ,  8'd0,   8'd0,   32'h0, 1);
    send_word(MODE_WRITE, 8'd0,   8'd7,   32'hFFFF_FFFF, 0);
    send_word(MODE_COUNT, 8'd7,   8'd0,   32'h0, 0);
    send_word(MODE_READ,  8'd0,   8'd7,   32'h0, 0);
    send_word(MODE_WRITE, 8'd0,   8'd200, 32'hA5A5_A5A5, 0);
    send_word(MODE_READ,  8'd0,   8'd200, 32'h0, 0);
    send_word(MODE_NONE,  8'hFF,  8'hFF,  32'hFFFF_FFFF, 0);
    send_word(MODE_COUNT, 8'd9,   8'd0,   32'h0, 0);
    send_word(MODE_COUNT, 8'd9,   8'd0,   32'h0, 0);
    send_word(MODE_COUNT, 8'd9,   8'd0,   32'h0, 0);
    send_word(MODE_READ,  8'd0,   8'd9,   32'h0, 2);

    // A lowered top hides upper bins until it is raised again.
    write_max_level(8'd100);
    send_word(MODE_COUNT, 8'd101, 8'd0,   32'h0, 0);
    send_word(MODE_READ,  8'd0,   8'd255, 32'h0, 0);
    send_word(MODE_WRITE, 8'd0,   8'd150, 32'h1234_5678, 0);
    send_word(MODE_COUNT, 8'd100, 8'd0,   32'h0, 0);
    send_word(MODE_READ,  8'd0,   8'd100, 32'h0, 0);
    send_word(MODE_READ,  8'd0,   8'd200, 32'h0, 0);
    write_max_level(8'd0);
    send_word(MODE_COUNT, 8'd0,   8'd0,   32'h0, 0);
    send_word(MODE_COUNT, 8'd1,   8'd0,   32'h0, 0);
    send_word(MODE_READ,  8'd0,   8'd0,   32'h0, 0);
    write_max_level(8'd255);
    send_word(MODE_READ,  8'd0,   8'd200, 32'h0, 0);

    phase_levels[0] = 8'd255;
    phase_levels[1] = 8'd0;
    phase_levels[2] = 8'd1;
    phase_levels[3] = 8'd254;
    phase_levels[4] = 8'($urandom_range(0, 255));
    phase_levels[5] = 8'd255;
    phase_levels[6] = 8'($urandom_range(2, 20));
    phase_levels[7] = 8'($urandom_range(0, 255));

    for (int p = 0; p < 8; p++) begin
      write_max_level(phase_levels[p]);
      quiet = (p == 5);
      for (int n = 0; n < 206; n++) begin
        if (p == 3 && n == 100) begin
          wait_drained();
        end
        r = $urandom_range(0, 99);
        if (r < 45) mode = MODE_COUNT;
        else if (r < 70) mode = MODE_READ;
        else if (r < 93) mode = MODE_WRITE;
        else mode = MODE_NONE;
        if ($urandom_range(0, 15) == 0) begin
          hot_bin = 8'($urandom_range(0, cur_level));
        end
        send_word(mode, pick_level(), pick_level(), pick_count(), pick_gap(quiet));
      end
    end

    start <= 1'b0;
    for (int w = 0; w < 1000 && pending != 0; w++) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/phist_pkg.sv
rtl/core/phist_ram.sv
rtl/core/phist_bins.sv
rtl/core/pixel_histogram.sv
test/phist_checker.sv
test/testbench.sv
